>>> hdl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg - shared constants for the barycentric weight pipeline
// Default widths used by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Width of one coordinate word (signed fixed point; the fraction width
  // has no effect on the weights, which are scale invariant).
  localparam int unsigned CoordBitsDef      = 16;
  // Fraction bits of each weight.
  localparam int unsigned WeightFracBitsDef = 16;
  // Integer bits of each weight, sign included.
  localparam int unsigned WeightIntBits     = 8;

endpackage

>>> hdl/tbc_pt_if.sv
// ----------------------------------------------------------------------------
// tbc_pt_if - query point and triangle channel
// Valid/ready channel carrying a point P and vertices A, B, C.
// ----------------------------------------------------------------------------
interface tbc_pt_if #(
  parameter int unsigned COORD_BITS = tbc_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p_x;
  logic signed [COORD_BITS-1:0] p_y;
  logic signed [COORD_BITS-1:0] p_z;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] c_z;

  modport source (
    output valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

>>> hdl/tbc_wt_if.sv
// ----------------------------------------------------------------------------
// tbc_wt_if - barycentric weight channel
// Valid/ready channel carrying three weights and a degenerate flag.
// ----------------------------------------------------------------------------
interface tbc_wt_if #(
  parameter int unsigned WEIGHT_FRAC_BITS = tbc_pkg::WeightFracBitsDef
);
  localparam int unsigned WB = tbc_pkg::WeightIntBits + WEIGHT_FRAC_BITS;

  logic                 valid;
  logic                 ready;
  logic signed [WB-1:0] weight_alpha;
  logic signed [WB-1:0] weight_beta;
  logic signed [WB-1:0] weight_gamma;
  logic                 degenerate;

  modport source (
    output valid, weight_alpha, weight_beta, weight_gamma, degenerate,
    input  ready
  );
  modport sink (
    input  valid, weight_alpha, weight_beta, weight_gamma, degenerate,
    output ready
  );
endinterface

>>> hdl/triangle_barycentric_coords.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords - barycentric weights of a point in a triangle
// Edge vectors, five dot products, Gram determinant, then three pipelined
// restoring dividers give alpha, beta and gamma, rounded and saturated.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  pt_i    | in  | valid / ready | p_x..c_z, COORD_BITS each, signed
//  wt_o    | out | valid / ready | weight_alpha/beta/gamma, degenerate
//
//  One transaction may enter every cycle while the output is not stalled;
//  the divider resolves one quotient bit per stage.
//  rst_ni clears every stage valid bit asynchronously; data registers hold.
//  Each stage loads whenever it is empty or the next stage takes its
//  contents, so bubbles close up and a stalled output loses nothing.
//
module triangle_barycentric_coords #(
  parameter int unsigned COORD_BITS       = tbc_pkg::CoordBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = tbc_pkg::WeightFracBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tbc_pt_if.sink   pt_i,
  tbc_wt_if.source wt_o
);

  localparam int unsigned EW  = COORD_BITS + 1;          // edge component
  localparam int unsigned PW  = 2 * EW;                  // component product
  localparam int unsigned DW  = PW + 2;                  // dot product
  localparam int unsigned LOW = DW / 2;                  // multiplier split
  localparam int unsigned BW  = 2 * DW;                  // wide product
  localparam int unsigned NW  = BW + 3;                  // numerators
  localparam int unsigned QB  = tbc_pkg::WeightIntBits + WEIGHT_FRAC_BITS;
  localparam int unsigned RW  = NW + QB + 2;             // divider remainder

  localparam int unsigned OPA [6] = '{0, 1, 3, 4, 4, 3};
  localparam int unsigned OPB [6] = '{2, 1, 2, 1, 0, 1};

  localparam logic [QB-1:0] HALF = QB'(1) << (QB - 1);
  localparam logic [QB-1:0] WMAX = HALF - QB'(1);

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
  logic r1, r2, r3, r4, r5, r6, r7, ro;
  logic vd_q  [QB+1];
  logic rd    [QB+1];

  assign ro = !vo_q || wt_o.ready;
  assign rd[QB] = !vd_q[QB] || ro;
  for (genvar j = 0; j < QB; j++) begin : g_rdy
    assign rd[j] = !vd_q[j] || rd[j+1];
  end
  assign r7 = !v7_q || rd[0];
  assign r6 = !v6_q || r7;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign pt_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
      for (int j = 0; j <= QB; j++) vd_q[j] <= 1'b0;
    end else begin
      if (r1) v1_q <= pt_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (r6) v6_q <= v5_q;
      if (r7) v7_q <= v6_q;
      if (rd[0]) vd_q[0] <= v7_q;
      for (int j = 0; j < QB; j++) begin
        if (rd[j+1]) vd_q[j+1] <= vd_q[j];
      end
      if (ro) vo_q <= vd_q[QB];
    end
  end

  // ---------------- stage 1: edge vectors ----------------
  logic signed [EW-1:0] e0_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_ff @(posedge clk_i) begin
    if (r1 && pt_i.valid) begin
      e0_q[0] <= EW'(pt_i.b_x) - EW'(pt_i.a_x);
      e0_q[1] <= EW'(pt_i.b_y) - EW'(pt_i.a_y);
      e0_q[2] <= EW'(pt_i.b_z) - EW'(pt_i.a_z);
      e1_q[0] <= EW'(pt_i.c_x) - EW'(pt_i.a_x);
      e1_q[1] <= EW'(pt_i.c_y) - EW'(pt_i.a_y);
      e1_q[2] <= EW'(pt_i.c_z) - EW'(pt_i.a_z);
      e2_q[0] <= EW'(pt_i.p_x) - EW'(pt_i.a_x);
      e2_q[1] <= EW'(pt_i.p_y) - EW'(pt_i.a_y);
      e2_q[2] <= EW'(pt_i.p_z) - EW'(pt_i.a_z);
    end
  end

  // ---------------- stage 2: component products ----------------
  // order: d00, d01, d11, d20, d21
  logic signed [PW-1:0] m2_q [5][3];

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      for (int i = 0; i < 3; i++) begin
        m2_q[0][i] <= e0_q[i] * e0_q[i];
        m2_q[1][i] <= e0_q[i] * e1_q[i];
        m2_q[2][i] <= e1_q[i] * e1_q[i];
        m2_q[3][i] <= e2_q[i] * e0_q[i];
        m2_q[4][i] <= e2_q[i] * e1_q[i];
      end
    end
  end

  // ---------------- stage 3: dot products ----------------
  logic signed [DW-1:0] d3_q [5];

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      for (int k = 0; k < 5; k++) begin
        d3_q[k] <= DW'(m2_q[k][0]) + DW'(m2_q[k][1]) + DW'(m2_q[k][2]);
      end
    end
  end

  // ---------------- stage 4: split partial products ----------------
  logic signed [DW+LOW:0]      pl4_q [6];
  logic signed [2*DW-LOW-1:0]  ph4_q [6];

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      for (int k = 0; k < 6; k++) begin
        pl4_q[k] <= d3_q[OPA[k]] * $signed({1'b0, d3_q[OPB[k]][LOW-1:0]});
        ph4_q[k] <= d3_q[OPA[k]] * $signed(d3_q[OPB[k]][DW-1:LOW]);
      end
    end
  end

  // ---------------- stage 5: wide products ----------------
  logic signed [BW-1:0] p5_q [6];

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      for (int k = 0; k < 6; k++) begin
        p5_q[k] <= (BW'(ph4_q[k]) <<< LOW) + BW'(pl4_q[k]);
      end
    end
  end

  // ---------------- stage 6: determinant and numerators ----------------
  logic signed [NW-1:0] det6_q, nb6_q, nc6_q;
  logic                 deg6_q;

  always_ff @(posedge clk_i) begin
    if (r6 && v5_q) begin
      det6_q <= NW'(p5_q[0]) - NW'(p5_q[1]);
      nb6_q  <= NW'(p5_q[2]) - NW'(p5_q[3]);
      nc6_q  <= NW'(p5_q[4]) - NW'(p5_q[5]);
      deg6_q <= (p5_q[0] == p5_q[1]);
    end
  end

  // ---------------- stage 7: magnitudes and signs ----------------
  logic signed [NW-1:0] num7 [3];
  logic [NW-1:0]        mag7_q [3];
  logic                 neg7_q [3];
  logic [NW-1:0]        magd7_q;
  logic                 deg7_q;

  assign num7[0] = det6_q - nb6_q - nc6_q;
  assign num7[1] = nb6_q;
  assign num7[2] = nc6_q;

  always_ff @(posedge clk_i) begin
    if (r7 && v6_q) begin
      for (int l = 0; l < 3; l++) begin
        mag7_q[l] <= num7[l][NW-1] ? NW'(-num7[l]) : NW'(num7[l]);
        neg7_q[l] <= num7[l][NW-1] ^ det6_q[NW-1];
      end
      magd7_q <= det6_q[NW-1] ? NW'(-det6_q) : NW'(det6_q);
      deg7_q  <= deg6_q;
    end
  end

  // ---------------- divider: setup then one quotient bit per stage ----------
  // ratio * 2^F rounded half away: floor((2n * 2^F + d) / 2d)
  logic [RW-1:0] r_q   [QB+1][3];
  logic [RW-1:0] dd_q  [QB+1][3];
  logic [QB-1:0] q_q   [QB+1][3];
  logic          ng_q  [QB+1][3];
  logic          ov_q  [QB+1][3];
  logic          dg_q  [QB+1];

  logic [RW-1:0] m7 [3];
  logic [RW-1:0] dd7;

  assign dd7 = RW'(magd7_q) << 1;
  for (genvar l = 0; l < 3; l++) begin : g_setup
    assign m7[l] = (RW'(mag7_q[l]) << (WEIGHT_FRAC_BITS + 1)) + RW'(magd7_q);
  end

  always_ff @(posedge clk_i) begin
    if (rd[0] && v7_q) begin
      for (int l = 0; l < 3; l++) begin
        r_q[0][l]  <= m7[l];
        dd_q[0][l] <= dd7;
        q_q[0][l]  <= '0;
        ng_q[0][l] <= neg7_q[l];
        // flag a quotient too large for the weight word
        ov_q[0][l] <= (m7[l] >= (dd7 << QB));
      end
      dg_q[0] <= deg7_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int unsigned BI = QB - 1 - j;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW:0]   t;
      logic [QB-1:0] q_d;

      assign t = {1'b0, r_q[j][l]} - {1'b0, (dd_q[j][l] << BI)};
      always_comb begin
        q_d     = q_q[j][l];
        q_d[BI] = !t[RW];
      end

      always_ff @(posedge clk_i) begin
        if (rd[j+1] && vd_q[j]) begin
          r_q[j+1][l]  <= t[RW] ? r_q[j][l] : t[RW-1:0];
          dd_q[j+1][l] <= dd_q[j][l];
          q_q[j+1][l]  <= q_d;
          ng_q[j+1][l] <= ng_q[j][l];
          ov_q[j+1][l] <= ov_q[j][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd[j+1] && vd_q[j]) dg_q[j+1] <= dg_q[j];
    end
  end

  // ---------------- output: sign, saturate, degenerate ----------------
  logic [QB-1:0] w_d [3];
  logic [QB-1:0] w_q [3];
  logic          deg_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dg_q[QB]) begin
        w_d[l] = '0;
      end else if (ng_q[QB][l]) begin
        w_d[l] = (ov_q[QB][l] || q_q[QB][l] > HALF) ? HALF : QB'(-q_q[QB][l]);
      end else begin
        w_d[l] = (ov_q[QB][l] || q_q[QB][l] > WMAX) ? WMAX : q_q[QB][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ro && vd_q[QB]) begin
      for (int l = 0; l < 3; l++) w_q[l] <= w_d[l];
      deg_q <= dg_q[QB];
    end
  end

  assign wt_o.valid        = vo_q;
  assign wt_o.weight_alpha = $signed(w_q[0]);
  assign wt_o.weight_beta  = $signed(w_q[1]);
  assign wt_o.weight_gamma = $signed(w_q[2]);
  assign wt_o.degenerate   = deg_q;

endmodule
